// ----- hw/rtl/ertd_pkg.sv -----
// ----------------------------------------------------------------------------
// ertd_pkg
// Shared types, microcode program, tap tables and arithmetic helpers for the
// early-reflection tapped delay unit.
// ----------------------------------------------------------------------------
package ertd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 5;
    localparam int PC_W      = 5;
    localparam int BACK_W    = 12;
    localparam int TAPS_MAX  = 18;

    // Microcode operations.
    typedef enum logic [1:0] {
        UOP_WAIT,
        UOP_READ,
        UOP_DRAIN,
        UOP_EMIT
    } t_uop;

    // One control word: operation, tap driven by a read step, the address
    // that follows, and the target taken when the last enabled tap is read.
    typedef struct packed {
        t_uop              op;
        logic [TAP_W-1:0]  tap;
        logic [PC_W-1:0]   next;
        logic [PC_W-1:0]   jump;
    } t_uword;

    localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] PC_DRAIN = 5'd19;
    localparam logic [PC_W-1:0] PC_EMIT  = 5'd21;

    // Program: wait for a word, read eighteen taps (leaving early after the
    // last enabled one), drain the two pipeline stages, then present the sum.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w.op   = UOP_WAIT;
        w.tap  = '0;
        w.next = PC_WAIT;
        w.jump = PC_DRAIN;
        if (pc == PC_WAIT) begin
            w.op   = UOP_WAIT;
            w.next = 5'd1;
        end else if (pc <= 5'd18) begin
            w.op   = UOP_READ;
            w.tap  = pc - 5'd1;
            w.next = pc + 5'd1;
        end else if (pc < PC_EMIT) begin
            w.op   = UOP_DRAIN;
            w.next = pc + 5'd1;
        end else if (pc == PC_EMIT) begin
            w.op   = UOP_EMIT;
            w.next = PC_WAIT;
        end
        return w;
    endfunction

    // Distance back from the current slot for each tap (tap delay minus one).
    function automatic logic [BACK_W-1:0] tap_back(input logic [TAP_W-1:0] tap);
        case (tap)
            5'd0:    tap_back = 12'd189;
            5'd1:    tap_back = 12'd948;
            5'd2:    tap_back = 12'd992;
            5'd3:    tap_back = 12'd1182;
            5'd4:    tap_back = 12'd1191;
            5'd5:    tap_back = 12'd1314;
            5'd6:    tap_back = 12'd2020;
            5'd7:    tap_back = 12'd2139;
            5'd8:    tap_back = 12'd2523;
            5'd9:    tap_back = 12'd2589;
            5'd10:   tap_back = 12'd2624;
            5'd11:   tap_back = 12'd2699;
            5'd12:   tap_back = 12'd3118;
            5'd13:   tap_back = 12'd3122;
            5'd14:   tap_back = 12'd3201;
            5'd15:   tap_back = 12'd3267;
            5'd16:   tap_back = 12'd3320;
            5'd17:   tap_back = 12'd3514;
            default: tap_back = 12'd0;
        endcase
    endfunction

    // Q15 tap gains.
    function automatic logic signed [SAMPLE_W-1:0] tap_weight(input logic [TAP_W-1:0] tap);
        case (tap)
            5'd0:    tap_weight = 16'sd27557;
            5'd1:    tap_weight = 16'sd16515;
            5'd2:    tap_weight = 16'sd16056;
            5'd3:    tap_weight = 16'sd12419;
            5'd4:    tap_weight = 16'sd12451;
            5'd5:    tap_weight = 16'sd11337;
            5'd6:    tap_weight = 16'sd9469;
            5'd7:    tap_weight = 16'sd8912;
            5'd8:    tap_weight = 16'sd6291;
            5'd9:    tap_weight = 16'sd6324;
            5'd10:   tap_weight = 16'sd7110;
            5'd11:   tap_weight = 16'sd5931;
            5'd12:   tap_weight = 16'sd5898;
            5'd13:   tap_weight = 16'sd5931;
            5'd14:   tap_weight = 16'sd5767;
            5'd15:   tap_weight = 16'sd4653;
            5'd16:   tap_weight = 16'sd5472;
            5'd17:   tap_weight = 16'sd4390;
            default: tap_weight = 16'sd0;
        endcase
    endfunction

    // Clamp a 17-bit signed value to the signed 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
        if (v > 17'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -17'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/ertd_ram.sv -----
// ----------------------------------------------------------------------------
// ertd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ertd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/early_reflection_tapped_delay_unit.sv -----
// ----------------------------------------------------------------------------
// early_reflection_tapped_delay_unit
// From the edge that accepts an input word to the edge that makes its output word
// valid, the sequencer runs the tap reads, 2 drain steps and 1 emit step. No new
// word is taken until the emit step fires, which waits while an earlier output word
// is still held; the delay RAM's single read port serves one tap per cycle.
// Reset (synchronous, active low) clears the write pointer, fill count, sequencer
// and output valid; the fill count makes unwritten slots read as zero, no sweep.
// ----------------------------------------------------------------------------
module early_reflection_tapped_delay_unit #(
    parameter int RING_DEPTH = 4096,
    parameter int TAP_COUNT  = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] reflections_out
);

    // Address and fill-count widths follow the ring depth.
    localparam int AW   = $clog2(RING_DEPTH);
    localparam int FW   = $clog2(RING_DEPTH + 1);
    localparam int NTAP = (TAP_COUNT > ertd_pkg::TAPS_MAX) ? ertd_pkg::TAPS_MAX : TAP_COUNT;
    localparam logic [ertd_pkg::TAP_W-1:0] LAST_TAP = ertd_pkg::TAP_W'(NTAP - 1);

    // Sequencer and control state.
    logic [ertd_pkg::PC_W-1:0] r_pc, n_pc;
    logic [AW-1:0]             r_wp, n_wp;
    logic [FW-1:0]             r_fill, n_fill;
    logic                      r_v1, r_v2;
    logic                      r_out_valid, n_out_valid;

    // Datapath registers.
    logic                               r_ok1;
    logic [ertd_pkg::TAP_W-1:0]         r_tap1;
    logic signed [15:0]                 r_term;
    logic signed [15:0]                 r_acc;
    logic [15:0]                        r_out_data;

    ertd_pkg::t_uword              uword;
    logic                          accept;
    logic                          emit_fire;
    logic [ertd_pkg::BACK_W-1:0]   back;
    logic [AW:0]                   diff;
    logic [AW-1:0]                 slot;
    logic                          tap_ok;
    logic [15:0]                   ram_q;
    logic signed [15:0]            data_m;
    logic signed [31:0]            prod;
    logic signed [15:0]            term;
    logic signed [16:0]            acc_sum;

    // The current control word comes straight from the microcode table.
    assign uword     = ertd_pkg::uc_rom(r_pc);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign emit_fire = (uword.op == ertd_pkg::UOP_EMIT) && (!r_out_valid || m_axis_tready);

    // Input is taken only in the wait step; the output register lets the
    // next word in while the previous result is still pending downstream.
    assign s_axis_tready = (uword.op == ertd_pkg::UOP_WAIT);

    // Tap address: current slot minus the tap distance, modulo the ring depth.
    assign back = ertd_pkg::tap_back(uword.tap);
    assign diff = {1'b0, r_wp} - {1'b0, AW'(back)};
    assign slot = diff[AW] ? AW'(diff[AW-1:0] + AW'(RING_DEPTH)) : diff[AW-1:0];

    // A slot that has not been written since reset reads as zero. The fill
    // count includes the word just written, so the tap is live when its
    // distance back is below the count.
    assign tap_ok = FW'(back) < r_fill;

    ertd_ram #(
        .WIDTH (16),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata),
        .i_raddr (slot),
        .o_rdata (ram_q)
    );

    // Stage two: Q15 multiply with floor shift and saturation.
    assign data_m = r_ok1 ? $signed(ram_q) : 16'sd0;
    assign prod   = data_m * ertd_pkg::tap_weight(r_tap1);
    assign term   = ertd_pkg::sat16(prod[31:15]);

    // Stage three: saturating accumulate in tap order.
    assign acc_sum = {r_acc[15], r_acc} + {r_term[15], r_term};

    // Next-state logic for the sequencer and pointers.
    always_comb begin
        n_pc        = r_pc;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (uword.op)
            ertd_pkg::UOP_WAIT: begin
                if (accept) begin
                    n_pc = uword.next;
                    if (r_fill != FW'(RING_DEPTH)) begin
                        n_fill = r_fill + FW'(1);
                    end
                end
            end
            ertd_pkg::UOP_READ: begin
                // Leave the tap loop after the last enabled tap.
                n_pc = (uword.tap == LAST_TAP) ? uword.jump : uword.next;
            end
            ertd_pkg::UOP_DRAIN: begin
                n_pc = uword.next;
            end
            ertd_pkg::UOP_EMIT: begin
                if (emit_fire) begin
                    n_pc        = uword.next;
                    n_out_valid = 1'b1;
                    n_wp        = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                end
            end
            default: begin
                n_pc = ertd_pkg::PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ertd_pkg::PC_WAIT;
            r_wp        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_v1        <= (uword.op == ertd_pkg::UOP_READ);
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_ok1  <= tap_ok;
        r_tap1 <= uword.tap;
        if (r_v1) begin
            r_term <= term;
        end
        if (accept) begin
            r_acc <= 16'sd0;
        end else if (r_v2) begin
            r_acc <= ertd_pkg::sat16(acc_sum);
        end
        if (emit_fire) begin
            r_out_data <= r_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hw/rtl/ertd_checker.sv -----
// ----------------------------------------------------------------------------
// ertd_checker
// Port-level checks for the early-reflection tapped delay unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module ertd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Reset leaves the block empty and ready for a word.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

    // A stalled output word keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

    // After a word is taken the block stays busy; checked at the start of the tap reads.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted again during tap processing");

    // A new result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without processing");

endmodule

bind early_reflection_tapped_delay_unit ertd_checker u_ertd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/testbench.sv -----
// ============================================================================
// Early-reflection tapped delay unit testbench
// Streams signed Q15 samples into the unit and checks every reflection sum
// against a cycle-free predictor of the eighteen-tap delay line.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = ertd_pkg::SAMPLE_W;

    // The predictor keeps its own ring of this depth and sums this many taps.
    localparam int RING_DEPTH   = 4096;
    localparam int TAP_COUNT    = 18;

    // The random part brings the run to about 1300 words, so the shorter taps
    // read written samples while the longer ones still read cleared slots.
    localparam int RANDOM_WORDS = 1275;

    // The run stops if this many cycles pass with no word moving on either side.
    // The longest correct quiet stretch is the forced output hold-off below.
    localparam int IDLE_LIMIT   = 10000;

    // Output hold-off that lets the unit fill up and stall its input.
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 2500;

    // Cycles to watch for stray output words after the last expected one.
    localparam int SETTLE_CYCLES = 66;

    typedef enum int {
        MIX_FULL,       // uniform over the whole 16-bit range
        MIX_QUIET,      // small values near zero
        MIX_HOLD_MAX,   // long run of positive full scale
        MIX_HOLD_MIN,   // long run of negative full scale
        MIX_SWING       // alternating extremes
    } t_mix;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [SAMPLE_W-1:0]        s_axis_tdata = '0;   // [15:0] sample_in
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]        m_axis_tdata;        // [15:0] reflections_out

    early_reflection_tapped_delay_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the delay ring and its write slot.
    // Tap delays and Q15 gains are the fixed reflection pattern; a tap with
    // delay d reads the sample written d - 1 words before the current one.
    // ------------------------------------------------------------------------
    int tap_delay [0:17] = '{
        190, 949, 993, 1183, 1192, 1315,
        2021, 2140, 2524, 2590, 2625, 2700,
        3119, 3123, 3202, 3268, 3321, 3515
    };
    int tap_gain [0:17] = '{
        27557, 16515, 16056, 12419, 12451, 11337,
        9469, 8912, 6291, 6324, 7110, 5931,
        5898, 5931, 5767, 4653, 5472, 4390
    };

    logic signed [SAMPLE_W-1:0] delay_ring [RING_DEPTH];
    int                         ring_slot;
    int                         ring_wraps;

    logic [SAMPLE_W-1:0]        pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_sums[$];

    int samples_total;
    int samples_accepted;
    int sums_checked;
    int mismatch_count;
    bit stimulus_ready;

    function automatic int clamp16(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // Writes one sample into the ring and returns the weighted tap sum. Each
    // product is floored by the 15-bit shift and clamped, and the running sum
    // saturates after every tap, in tap order.
    function automatic logic signed [SAMPLE_W-1:0] reflect_sample(
        input logic signed [SAMPLE_W-1:0] sample
    );
        int sum;
        int term;
        int slot;
        sum = 0;
        delay_ring[ring_slot] = sample;
        for (int t = 0; t < TAP_COUNT; t++) begin
            slot = (ring_slot + RING_DEPTH - (tap_delay[t] - 1)) % RING_DEPTH;
            term = (int'(delay_ring[slot]) * tap_gain[t]) >>> 15;
            sum  = clamp16(sum + clamp16(term));
        end
        ring_slot = ring_slot + 1;
        if (ring_slot == RING_DEPTH) begin
            ring_slot  = 0;
            ring_wraps = ring_wraps + 1;
        end
        return sum[SAMPLE_W-1:0];
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 82) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 40);
        end
        return $urandom_range(41, 200);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: a directed opening, then random segments of varied character.
    // Long runs at full scale drive the tap sum into saturation in both
    // directions; the quiet and full-range segments keep it mostly linear.
    // ------------------------------------------------------------------------
    initial begin
        int   run_len;
        int   fill;
        t_mix mix;
        logic [SAMPLE_W-1:0] word;

        for (int i = 0; i < RING_DEPTH; i++) begin
            delay_ring[i] = '0;
        end
        ring_slot  = 0;
        ring_wraps = 0;

        // Extremes of the sample field and simple bit patterns. The early
        // words read only cleared slots on every tap.
        pending_samples = '{
            16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
            16'h5555, 16'haaaa, 16'h7ffe, 16'h8001, 16'h00ff,
            16'hff00, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
            16'h4000, 16'hc000, 16'h0f0f, 16'hf0f0, 16'h3fff,
            16'hc001, 16'h0100, 16'hfeff, 16'h7fff, 16'h8000
        };

        fill = 0;
        while (fill < RANDOM_WORDS) begin
            mix     = t_mix'($urandom_range(0, 4));
            run_len = (mix == MIX_HOLD_MAX || mix == MIX_HOLD_MIN)
                      ? $urandom_range(20, 400) : $urandom_range(1, 150);
            for (int k = 0; k < run_len && fill < RANDOM_WORDS; k++) begin
                case (mix)
                    MIX_QUIET:    word = SAMPLE_W'($signed($urandom_range(0, 400)) - 200);
                    MIX_HOLD_MAX: word = 16'h7fff;
                    MIX_HOLD_MIN: word = 16'h8000;
                    MIX_SWING:    word = k[0] ? 16'h7fff : 16'h8000;
                    default:      word = SAMPLE_W'($urandom);
                endcase
                pending_samples.push_back(word);
                fill++;
            end
        end

        samples_total  = pending_samples.size();
        stimulus_ready = 1'b1;

        // Reset is held low at the start and never again.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every sample to go in and every sum to come back.
        while (samples_accepted < samples_total || expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d reflection sums for %0d samples; the delay ring wrapped %0d time(s).",
                 sums_checked, samples_accepted, ring_wraps);
        $display("Saturating runs, cleared-slot reads on the longer taps and input stalls were exercised.");
        if (mismatch_count == 0 && expected_sums.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver. A word is accepted at an edge where tvalid and tready are
    // both high; the predictor runs on it right then, so expectations queue
    // up in acceptance order. A new word is offered only when the bus is free.
    // ------------------------------------------------------------------------
    int in_gap;
    int in_steady;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap        <= 0;
            in_steady     <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_sums.push_back(reflect_sample(s_axis_tdata));
                samples_accepted <= samples_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap        <= in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (stimulus_ready && pending_samples.size() != 0) begin
                    s_axis_tdata  <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    // Occasional steady stretches with no gaps at all.
                    if (in_steady > 0) begin
                        in_steady <= in_steady - 1;
                        in_gap    <= 0;
                    end else begin
                        if ($urandom_range(0, 59) == 0) begin
                            in_steady <= $urandom_range(30, 150);
                        end
                        in_gap <= pick_gap();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor and backpressure. Every accepted word is checked against
    // the oldest expected sum. tready drops for random stretches, and once,
    // after a few hundred sums, it stays low long enough that the unit holds
    // its result and refuses further input.
    // ------------------------------------------------------------------------
    int  out_hold;
    int  out_steady;
    bit  hold_off_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_hold      <= 0;
            out_steady    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_sums.size() == 0) begin
                    $error("reflections_out: unexpected word %0d with no sample pending",
                           $signed(m_axis_tdata));
                    mismatch_count <= mismatch_count + 1;
                end else if (m_axis_tdata !== expected_sums[0]) begin
                    $error("reflections_out mismatch: expected %0d, actual %0d",
                           expected_sums[0], $signed(m_axis_tdata));
                    mismatch_count <= mismatch_count + 1;
                    void'(expected_sums.pop_front());
                end else begin
                    void'(expected_sums.pop_front());
                end
                sums_checked <= sums_checked + 1;
            end

            if (!hold_off_done && sums_checked >= HOLD_OFF_AT) begin
                hold_off_done <= 1'b1;
                out_hold      <= HOLD_OFF_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (out_hold > 0) begin
                out_hold      <= out_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (out_steady > 0) begin
                    out_steady <= out_steady - 1;
                end else begin
                    if ($urandom_range(0, 199) == 0) begin
                        out_steady <= $urandom_range(100, 2000);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        out_hold <= pick_gap();
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no word moves on either bus.
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/ertd_pkg.sv
hw/rtl/ertd_ram.sv
hw/rtl/early_reflection_tapped_delay_unit.sv
hw/rtl/ertd_checker.sv
tb/sv/testbench.sv
